// ===== design/segx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segx_pkg
// Shared types and constants for the segment intersection test.
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    ORIENT_COLINEAR = 2'd0,
    ORIENT_CW       = 2'd1,
    ORIENT_CCW      = 2'd2
  } orient_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== design/segx_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segx_in_if
// Input channel: endpoints of two segments, valid/ready handshake.
// ----------------------------------------------------------------------------
interface segx_in_if #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_start_x;
  logic signed [COORD_WIDTH-1:0] first_start_y;
  logic signed [COORD_WIDTH-1:0] first_end_x;
  logic signed [COORD_WIDTH-1:0] first_end_y;
  logic signed [COORD_WIDTH-1:0] second_start_x;
  logic signed [COORD_WIDTH-1:0] second_start_y;
  logic signed [COORD_WIDTH-1:0] second_end_x;
  logic signed [COORD_WIDTH-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== design/segx_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segx_out_if
// Output channel: one intersection flag per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface segx_out_if;
  logic valid;
  logic ready;
  logic segments_cross;

  modport source (output valid, segments_cross, input ready);
  modport sink (input valid, segments_cross, output ready);
endinterface
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== design/segment_intersection_test_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Decides whether two closed 2D segments intersect or touch.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// flag per word, in order. From accept to result valid the stages are:
// coordinate differences and bounding-box compares, the eight exact
// products, the four orientations, then the output register. The per-stage
// valid/ready chain sets this rate; a stalled output back-pressures stage by
// stage so bubbles are squeezed out before the input is held off.
// ----------------------------------------------------------------------------
module segment_intersection_test_top #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  segx_in_if.sink    coords,
  segx_out_if.source result
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;

  typedef logic signed [DW-1:0] diff_t;

  function automatic diff_t sub(input logic [W-1:0] a, input logic [W-1:0] b);
    sub = $signed({a[W-1], a}) - $signed({b[W-1], b});
  endfunction

  function automatic logic in_box(
    input logic signed [W-1:0] px, input logic signed [W-1:0] py,
    input logic signed [W-1:0] qx, input logic signed [W-1:0] qy,
    input logic signed [W-1:0] rx, input logic signed [W-1:0] ry
  );
    logic in_x;
    logic in_y;
    in_x = (qx >= px && qx <= rx) || (qx >= rx && qx <= px);
    in_y = (qy >= py && qy <= ry) || (qy >= ry && qy <= py);
    in_box = in_x && in_y;
  endfunction

  // stage control
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !result.valid || result.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign coords.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= coords.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) result.valid <= v3;
    end
  end

  // stage 1: differences and box tests
  diff_t d_ab_y, d_ab_x, d_bc_x, d_bc_y, d_bd_x, d_bd_y;
  diff_t d_cd_y, d_cd_x, d_da_x, d_da_y, d_db_x, d_db_y;
  logic [3:0] box1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d_ab_y <= sub(coords.first_end_y, coords.first_start_y);
      d_ab_x <= sub(coords.first_end_x, coords.first_start_x);
      d_bc_x <= sub(coords.second_start_x, coords.first_end_x);
      d_bc_y <= sub(coords.second_start_y, coords.first_end_y);
      d_bd_x <= sub(coords.second_end_x, coords.first_end_x);
      d_bd_y <= sub(coords.second_end_y, coords.first_end_y);
      d_cd_y <= sub(coords.second_end_y, coords.second_start_y);
      d_cd_x <= sub(coords.second_end_x, coords.second_start_x);
      d_da_x <= sub(coords.first_start_x, coords.second_end_x);
      d_da_y <= sub(coords.first_start_y, coords.second_end_y);
      d_db_x <= sub(coords.first_end_x, coords.second_end_x);
      d_db_y <= sub(coords.first_end_y, coords.second_end_y);
      box1[0] <= in_box(coords.first_start_x, coords.first_start_y,
                        coords.second_start_x, coords.second_start_y,
                        coords.first_end_x, coords.first_end_y);
      box1[1] <= in_box(coords.first_start_x, coords.first_start_y,
                        coords.second_end_x, coords.second_end_y,
                        coords.first_end_x, coords.first_end_y);
      box1[2] <= in_box(coords.second_start_x, coords.second_start_y,
                        coords.first_start_x, coords.first_start_y,
                        coords.second_end_x, coords.second_end_y);
      box1[3] <= in_box(coords.second_start_x, coords.second_start_y,
                        coords.first_end_x, coords.first_end_y,
                        coords.second_end_x, coords.second_end_y);
    end
  end

  // stages 2 and 3: products and orientations
  segx_pkg::orient_t o1, o2, o3, o4;

  segx_turn #(.COORD_WIDTH(W)) u_turn1 (
    .clk(clk), .prod_en(rdy2), .orient_en(rdy3),
    .dqp_y(d_ab_y), .drq_x(d_bc_x), .dqp_x(d_ab_x), .drq_y(d_bc_y),
    .orient(o1)
  );
  segx_turn #(.COORD_WIDTH(W)) u_turn2 (
    .clk(clk), .prod_en(rdy2), .orient_en(rdy3),
    .dqp_y(d_ab_y), .drq_x(d_bd_x), .dqp_x(d_ab_x), .drq_y(d_bd_y),
    .orient(o2)
  );
  segx_turn #(.COORD_WIDTH(W)) u_turn3 (
    .clk(clk), .prod_en(rdy2), .orient_en(rdy3),
    .dqp_y(d_cd_y), .drq_x(d_da_x), .dqp_x(d_cd_x), .drq_y(d_da_y),
    .orient(o3)
  );
  segx_turn #(.COORD_WIDTH(W)) u_turn4 (
    .clk(clk), .prod_en(rdy2), .orient_en(rdy3),
    .dqp_y(d_cd_y), .drq_x(d_db_x), .dqp_x(d_cd_x), .drq_y(d_db_y),
    .orient(o4)
  );

  logic [3:0] box2, box3;

  always_ff @(posedge clk) begin
    if (rdy2) box2 <= box1;
    if (rdy3) box3 <= box2;
  end

  // stage 4: decision
  logic hit;

  always_comb begin
    hit = (o1 != o2 && o3 != o4)
       || (o1 == segx_pkg::ORIENT_COLINEAR && box3[0])
       || (o2 == segx_pkg::ORIENT_COLINEAR && box3[1])
       || (o3 == segx_pkg::ORIENT_COLINEAR && box3[2])
       || (o4 == segx_pkg::ORIENT_COLINEAR && box3[3]);
  end

  always_ff @(posedge clk) begin
    if (rdy4) result.segments_cross <= hit;
  end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== design/segx_turn.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segx_turn
// Orientation of one point against a segment: two registered products,
// then a registered sign/zero test of their difference.
// ----------------------------------------------------------------------------
module segx_turn #(
  parameter int unsigned COORD_WIDTH = segx_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        prod_en,
  input  wire logic                        orient_en,
  input  wire logic signed [COORD_WIDTH:0] dqp_y,
  input  wire logic signed [COORD_WIDTH:0] drq_x,
  input  wire logic signed [COORD_WIDTH:0] dqp_x,
  input  wire logic signed [COORD_WIDTH:0] drq_y,
  output segx_pkg::orient_t                orient
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic        [PW:0]   cross_diff;

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_a <= PW'(dqp_y) * PW'(drq_x);
      prod_b <= PW'(dqp_x) * PW'(drq_y);
    end
  end

  assign cross_diff = {prod_a[PW-1], prod_a} - {prod_b[PW-1], prod_b};

  always_ff @(posedge clk) begin
    if (orient_en) begin
      if (cross_diff[PW]) begin
        orient <= segx_pkg::ORIENT_CCW;
      end else if (cross_diff == '0) begin
        orient <= segx_pkg::ORIENT_COLINEAR;
      end else begin
        orient <= segx_pkg::ORIENT_CW;
      end
    end
  end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
